@@ rtl/core/lprm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lprm_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
        logic [31:0] seq;
        logic        ack_ok;
        logic        seq_checked;
        logic [31:0] session_tag;
        logic [7:0]  unit_id;
        logic [7:0]  fail_count;
    } in_item_t;

    typedef struct packed {
        logic        ping_due;
        logic        peer_valid;
        logic [31:0] last_rtt_ms;
        logic [15:0] avg_rtt_ms;
        logic [31:0] last_pong_ms;
        logic [31:0] pings_sent;
        logic [31:0] pings_ok;
        logic [31:0] pings_missed;
        logic [31:0] miss_streak;
        logic [31:0] seq_gap_total;
        logic [31:0] seq_rewinds;
    } out_item_t;

    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_SENT  = 3'd1;
    localparam logic [2:0] K_ACK   = 3'd2;
    localparam logic [2:0] K_STATE = 3'd3;
    localparam logic [2:0] K_HELLO = 3'd4;
    localparam logic [2:0] K_OK    = 3'd5;
    localparam logic [2:0] K_FAIL  = 3'd6;
    localparam logic [2:0] K_PEER  = 3'd7;

    localparam logic [1:0] CFG_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [7:0] UNIT_AIR = 8'd1;
    localparam logic [15:0] RTT_SAT = 16'hFFFF;
    localparam logic [7:0] RUN_SAT = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    // request to the averaging unit
    typedef struct packed {
        logic start;
    } avg_req_t;

endpackage
`default_nettype wire

@@ rtl/core/lprm_avg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lprm_avg #(
    parameter int SUM_W = 22,
    parameter int CNT_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [15:0]           quotient
);
    // restoring divider, one quotient bit per cycle
    logic [SUM_W-1:0] q_reg, q_next;
    logic [SUM_W:0]   r_reg, r_next;
    logic [$clog2(SUM_W+1)-1:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic [SUM_W:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = '0;
        done = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            n_next = ($clog2(SUM_W+1))'(SUM_W);
            busy_next = (divisor != '0);
            done = (divisor == '0);
            if (divisor == '0)
                q_next = '0;
        end
        else if (busy_reg)
        begin
            trial = {r_reg[SUM_W-1:0], q_reg[SUM_W-1]};
            q_next = {q_reg[SUM_W-2:0], 1'b0};
            if (trial >= (SUM_W+1)'(divisor))
            begin
                r_next = trial - (SUM_W+1)'(divisor);
                q_next[0] = 1'b1;
            end
            else
                r_next = trial;
            n_next = n_reg - 1'b1;
            if (n_reg == 1)
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // final quotient is valid in the done cycle
    assign quotient = q_next[15:0];
endmodule
`default_nettype wire

@@ rtl/core/link_ping_rtt_monitor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sequence: after an input beat the ring is walked, one memory read per cycle, and
// the sum is divided bit-serially by the fill count; with an empty ring the divider
// answers zero at once and the divide state is skipped before the output beat
// throughput: one item at a time, next input beat taken the cycle after the output beat
// reset: asynchronous active low; config returns to 1000/1000/6, link state,
// counters and sequencer clear; ring entries beyond the fill count are never used
module link_ping_rtt_monitor #(
    parameter int RTT_SAMPLES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lprm_pkg::in_item_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lprm_pkg::out_item_t   out_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data
);
    localparam int PW = (RTT_SAMPLES > 1) ? $clog2(RTT_SAMPLES) : 1;
    localparam int FW = $clog2(RTT_SAMPLES + 1);
    localparam int SW = 16 + FW;

    // configuration registers
    logic [15:0] interval_reg, timeout_reg;
    logic [7:0]  thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd1000;
            timeout_reg  <= 16'd1000;
            thresh_reg   <= 8'd6;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lprm_pkg::CFG_INTERVAL:  interval_reg <= cfg_data;
                lprm_pkg::CFG_TIMEOUT:   timeout_reg  <= cfg_data;
                lprm_pkg::CFG_THRESHOLD: thresh_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // scalar link state
    logic        peer_reg, pend_reg, hseq_reg, hses_reg;
    logic [7:0]  run_reg;
    logic [31:0] tx_reg, att_reg, exp_reg, lseq_reg, ses_reg;
    logic [31:0] lrtt_reg, lpong_reg, sent_reg, ok_reg, miss_reg, strk_reg;
    logic [31:0] gap_reg, rew_reg;
    logic [PW-1:0] wpos_reg;
    logic [FW-1:0] fill_reg;
    logic        due_reg;

    // rtt ring memory, entries past fill never used
    logic [15:0] ring [RTT_SAMPLES];
    logic        ring_we;
    logic [PW-1:0] ring_waddr, raddr;
    logic [15:0] ring_wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[ring_waddr] <= ring_wdata;
        rdata_reg <= ring[raddr];
    end

    lprm_pkg::state_t state_reg, state_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          rd_ok_reg;
    logic [15:0]   avg_reg;
    logic          div_done;
    logic [15:0]   quot;
    lprm_pkg::avg_req_t req;

    logic acc;
    assign acc = in_valid && in_ready;

    // event decode, combinational
    lprm_pkg::in_item_t d;
    assign d = in_data;
    logic [31:0] age_tx, age_att, rtt;
    logic rec, miss, drop, due;
    logic [8:0] run_sum;
    logic [7:0] run_sat;
    assign age_tx  = d.now_ms - tx_reg;
    assign age_att = d.now_ms - att_reg;
    assign rtt     = d.now_ms - tx_reg;
    assign run_sum = {1'b0, run_reg} + {1'b0, d.fail_count};
    assign run_sat = run_sum[8] ? lprm_pkg::RUN_SAT : run_sum[7:0];

    always_comb
    begin
        rec = 1'b0;
        miss = 1'b0;
        drop = 1'b0;
        due = 1'b0;
        if (d.kind == lprm_pkg::K_TICK)
        begin
            miss = peer_reg && pend_reg && (age_tx >= {16'd0, timeout_reg});
            // first attempt or interval elapsed, only with a peer and no ping pending
            due  = peer_reg && !pend_reg &&
                   (att_reg == '0 || age_att >= {16'd0, interval_reg});
        end
        else if (d.kind == lprm_pkg::K_ACK)
        begin
            if (d.seq_checked)
            begin
                rec  = pend_reg && (d.seq == exp_reg) && d.ack_ok;
                miss = !rec && !d.ack_ok;
            end
            else
            begin
                rec  = pend_reg && d.ack_ok;
                miss = pend_reg && !d.ack_ok;
            end
        end
        else if (d.kind == lprm_pkg::K_FAIL)
            drop = (d.fail_count != 0) && peer_reg && (run_sat >= thresh_reg);
    end

    assign ring_we    = acc && rec;
    assign ring_waddr = wpos_reg;
    assign ring_wdata = (rtt > 32'h0000_FFFF) ? lprm_pkg::RTT_SAT : rtt[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_reg <= 1'b0; pend_reg <= 1'b0; hseq_reg <= 1'b0; hses_reg <= 1'b0;
            run_reg <= '0; tx_reg <= '0; att_reg <= '0; exp_reg <= '0;
            lseq_reg <= '0; ses_reg <= '0; lrtt_reg <= '0; lpong_reg <= '0;
            sent_reg <= '0; ok_reg <= '0; miss_reg <= '0; strk_reg <= '0;
            gap_reg <= '0; rew_reg <= '0; wpos_reg <= '0; fill_reg <= '0;
            due_reg <= 1'b0;
        end
        else if (acc)
        begin
            due_reg <= due;
            if (miss)
            begin
                miss_reg <= miss_reg + 1'b1;
                strk_reg <= strk_reg + 1'b1;
            end
            if (rec)
            begin
                lrtt_reg  <= rtt;
                lpong_reg <= d.now_ms;
                ok_reg    <= ok_reg + 1'b1;
                strk_reg  <= '0;
                wpos_reg  <= (wpos_reg == PW'(RTT_SAMPLES - 1)) ? '0 : wpos_reg + 1'b1;
                if (fill_reg < FW'(RTT_SAMPLES))
                    fill_reg <= fill_reg + 1'b1;
            end
            unique case (d.kind)
                lprm_pkg::K_TICK:
                begin
                    // timed-out ping is closed
                    if (miss)
                        pend_reg <= 1'b0;
                end
                lprm_pkg::K_SENT:
                begin
                    if (peer_reg)
                    begin
                        pend_reg <= 1'b1;
                        exp_reg  <= d.seq;
                        tx_reg   <= d.now_ms;
                        att_reg  <= d.now_ms;
                        sent_reg <= sent_reg + 1'b1;
                    end
                end
                lprm_pkg::K_ACK: pend_reg <= 1'b0;
                lprm_pkg::K_STATE:
                begin
                    if (hseq_reg)
                    begin
                        if (d.seq > lseq_reg)
                        begin
                            gap_reg  <= gap_reg + (d.seq - lseq_reg - 1'b1);
                            lseq_reg <= d.seq;
                        end
                        else
                            rew_reg <= rew_reg + 1'b1;
                    end
                    else
                    begin
                        lseq_reg <= d.seq;
                        hseq_reg <= 1'b1;
                    end
                end
                lprm_pkg::K_HELLO:
                begin
                    if (d.unit_id == lprm_pkg::UNIT_AIR)
                    begin
                        if (!hses_reg || d.session_tag != ses_reg)
                        begin
                            ses_reg  <= d.session_tag;
                            hses_reg <= 1'b1;
                            lseq_reg <= '0;
                            hseq_reg <= 1'b0;
                        end
                        peer_reg <= 1'b1;
                        run_reg  <= '0;
                    end
                end
                lprm_pkg::K_OK: run_reg <= '0;
                lprm_pkg::K_FAIL:
                begin
                    if (d.fail_count != 0 && peer_reg)
                    begin
                        run_reg <= drop ? '0 : run_sat;
                        if (drop)
                        begin
                            // drop peer, counters kept, last rtt and pong times cleared
                            peer_reg <= 1'b0; pend_reg <= 1'b0;
                            tx_reg <= '0; att_reg <= '0; exp_reg <= '0;
                            wpos_reg <= '0; fill_reg <= '0;
                            lseq_reg <= '0; hseq_reg <= 1'b0;
                            ses_reg <= '0; hses_reg <= 1'b0;
                            lrtt_reg <= '0; lpong_reg <= '0;
                        end
                    end
                end
                lprm_pkg::K_PEER:
                begin
                    peer_reg <= 1'b1;
                    run_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    // averaging sequencer: walk ring, then divide
    assign raddr = idx_reg[PW-1:0];
    assign req.start = (state_reg == lprm_pkg::ST_SUM) && !rd_ok_reg && (idx_reg >= fill_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lprm_pkg::ST_IDLE: if (acc) state_next = lprm_pkg::ST_SUM;
            // empty ring: divider answers zero at once
            lprm_pkg::ST_SUM:
                if (req.start)
                    state_next = (fill_reg == '0) ? lprm_pkg::ST_OUT : lprm_pkg::ST_DIV;
            lprm_pkg::ST_DIV:  if (div_done) state_next = lprm_pkg::ST_OUT;
            lprm_pkg::ST_OUT:  if (out_ready) state_next = lprm_pkg::ST_IDLE;
            default:           state_next = lprm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (state_reg == lprm_pkg::ST_IDLE)
        begin
            idx_next = '0;
            sum_next = '0;
        end
        else if (state_reg == lprm_pkg::ST_SUM)
        begin
            if (rd_ok_reg)
                sum_next = sum_reg + SW'(rdata_reg);
            if (idx_reg < fill_reg)
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lprm_pkg::ST_IDLE;
            idx_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            rd_ok_reg <= (state_reg == lprm_pkg::ST_SUM) && (idx_reg < fill_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (div_done)
            avg_reg <= quot;
    end

    lprm_avg #(.SUM_W(SW), .CNT_W(FW)) u_avg (
        .clk(clk), .rst_n(rst_n), .start(req.start), .dividend(sum_reg),
        .divisor(fill_reg), .done(div_done), .quotient(quot)
    );

    assign in_ready  = (state_reg == lprm_pkg::ST_IDLE);
    assign out_valid = (state_reg == lprm_pkg::ST_OUT);

    always_comb
    begin
        out_data.ping_due      = due_reg;
        out_data.peer_valid    = peer_reg;
        out_data.last_rtt_ms   = lrtt_reg;
        out_data.avg_rtt_ms    = avg_reg;
        out_data.last_pong_ms  = lpong_reg;
        out_data.pings_sent    = sent_reg;
        out_data.pings_ok      = ok_reg;
        out_data.pings_missed  = miss_reg;
        out_data.miss_streak   = strk_reg;
        out_data.seq_gap_total = gap_reg;
        out_data.seq_rewinds   = rew_reg;
    end
endmodule
`default_nettype wire
